// ===== rtl/core/rafb_pkg.sv =====
// Package for the radio API frame builder.
// Holds the item classes, the queue entry type and the frame constants.
// No dependencies.
`timescale 1ns / 1ps

package rafb_pkg;

    localparam logic [1:0] OP_CMD_HDR = 2'd0;
    localparam logic [1:0] OP_TX_HDR  = 2'd1;
    localparam logic [1:0] OP_PAYLOAD = 2'd2;
    localparam logic [1:0] OP_ESCAPE  = 2'd3;

    localparam logic [1:0] CFG_DEST_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_FRAME_ID       = 2'd1;
    localparam logic [1:0] CFG_QUERY_FRAME_ID = 2'd2;

    localparam logic [7:0] START_BYTE    = 8'h7E;
    localparam logic [7:0] TYPE_COMMAND  = 8'h08;
    localparam logic [7:0] TYPE_TRANSMIT = 8'h10;
    localparam logic [7:0] CHECK_BASE    = 8'hFF;
    localparam logic [7:0] BCAST_HI      = 8'hFF;
    localparam logic [7:0] BCAST_LO      = 8'hFE;
    localparam logic [8:0] CMD_OVERHEAD  = 9'd4;
    localparam logic [8:0] TX_OVERHEAD   = 9'd14;

    localparam int FIFO_DEPTH = 4;

    typedef enum logic [2:0] {
        K_CMD      = 3'd0,
        K_TX       = 3'd1,
        K_PAY      = 3'd2,
        K_PAY_LAST = 3'd3,
        K_STRAY    = 3'd4,
        K_ESC      = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] cmd_first;
        logic [7:0] cmd_second;
        logic [7:0] count;
        logic [7:0] data;
    } t_entry;

    function automatic logic [7:0] escape_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0, 3'd1, 3'd2: c = 8'h2B;
            3'd3:             c = 8'h41;
            3'd4:             c = 8'h50;
            3'd5:             c = 8'h31;
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/radio_api_frame_builder_top.sv =====
// Top level of the radio API frame builder: configuration registers and wiring.
// Depends on rafb_pkg, rafb_front, rafb_fifo and rafb_back.
//
// Input channel (i_valid / o_stall) takes one item per cycle while the queue
// has room: a command header, a transmit header, a payload byte or the mode
// escape. The front end classifies each item into a four-entry queue;
// o_stall rises only when that queue is full. The back end expands the head
// item into bytes on the output channel (o_valid / i_stall), one byte per
// cycle while i_stall is low, through an output register. A payload byte
// gives one result (two when it closes the frame with its checksum), so
// payload streams at one item per cycle while i_stall is low. A command
// header expands into 7 or 8 bytes, a transmit header into 17 or 18, an
// escape into 6. When the emitter is free, an accepted item is written into
// the queue and its first result then passes the output register before it
// is presented. While i_stall is high the output byte holds and the queue
// fills; the input side keeps accepting until it is full. Reset clears the
// frame state, the queue and the output valid, and loads the configuration
// registers with their defaults. Configuration writes (i_cfg_valid /
// o_cfg_ready) are always taken; an unknown index is dropped.
`timescale 1ns / 1ps

module radio_api_frame_builder_top #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_cmd_first,
    input  logic [7:0]  i_cmd_second,
    input  logic [7:0]  i_payload_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_end,
    output logic        o_frame_end,
    output logic        o_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import rafb_pkg::*;

    logic [63:0] r_dest_address;
    logic [7:0]  r_frame_id;
    logic [7:0]  r_query_frame_id;

    logic        accept;
    logic        push;
    logic        full;
    logic        pop;
    logic        head_valid;
    t_entry      entry;
    t_entry      head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign accept      = i_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_address   <= 64'h0013_A200_40B6_683D;
            r_frame_id       <= 8'h01;
            r_query_frame_id <= 8'h52;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEST_ADDRESS:   r_dest_address   <= i_cfg_data;
                CFG_FRAME_ID:       r_frame_id       <= i_cfg_data[7:0];
                CFG_QUERY_FRAME_ID: r_query_frame_id <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    rafb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_opcode         (i_opcode),
        .i_cmd_first      (i_cmd_first),
        .i_cmd_second     (i_cmd_second),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .o_push           (push),
        .o_entry          (entry)
    );

    rafb_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    rafb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .i_dest_address   (r_dest_address),
        .i_frame_id       (r_frame_id),
        .i_query_frame_id (r_query_frame_id),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_run_end        (o_run_end),
        .o_frame_end      (o_frame_end),
        .o_error          (o_error)
    );

endmodule

// ===== rtl/core/rafb_front.sv =====
// Front end of the radio API frame builder: accepts items and classifies them.
// Tracks the open frame and its remaining payload count. Uses rafb_pkg.
`timescale 1ns / 1ps

module rafb_front #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_cmd_first,
    input  logic [7:0]        i_cmd_second,
    input  logic [7:0]        i_payload_length,
    input  logic [7:0]        i_data_byte,
    output logic              o_push,
    output rafb_pkg::t_entry  o_entry
);
    import rafb_pkg::*;

    localparam logic [7:0] MAX_N = 8'(MAX_PAYLOAD);

    logic       r_open;
    logic       n_open;
    logic [7:0] r_remaining;
    logic [7:0] n_remaining;
    logic [7:0] count;

    assign count = (i_payload_length > MAX_N) ? MAX_N : i_payload_length;

    always_comb begin
        n_open              = r_open;
        n_remaining         = r_remaining;
        o_entry.kind        = K_STRAY;
        o_entry.cmd_first   = i_cmd_first;
        o_entry.cmd_second  = i_cmd_second;
        o_entry.count       = count;
        o_entry.data        = i_data_byte;
        case (i_opcode)
            OP_CMD_HDR, OP_TX_HDR: begin
                o_entry.kind = (i_opcode == OP_CMD_HDR) ? K_CMD : K_TX;
                n_open       = (count != 8'd0);
                n_remaining  = count;
            end
            OP_PAYLOAD: begin
                if (r_open) begin
                    n_remaining = r_remaining - 8'd1;
                    if (r_remaining == 8'd1) begin
                        o_entry.kind = K_PAY_LAST;
                        n_open       = 1'b0;
                    end else begin
                        o_entry.kind = K_PAY;
                    end
                end else begin
                    o_entry.kind = K_STRAY;
                end
            end
            default: begin
                o_entry.kind = K_ESC;
                n_open       = 1'b0;
                n_remaining  = 8'd0;
            end
        endcase
    end

    assign o_push = i_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= 8'd0;
        end else if (i_accept) begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

endmodule

// ===== rtl/core/rafb_fifo.sv =====
// Short queue between the front end and the byte emitter.
// Stores classified items in order. Uses rafb_pkg.
`timescale 1ns / 1ps

module rafb_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rafb_pkg::t_entry  i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_head_valid,
    output rafb_pkg::t_entry  o_head
);
    import rafb_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_entry          r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_pop;

    assign o_full       = (r_count == CW'(FIFO_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/rafb_back.sv =====
// Byte emitter of the radio API frame builder: expands queued items into bytes.
// Keeps the running checksum and the output register. Uses rafb_pkg.
`timescale 1ns / 1ps

module rafb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  rafb_pkg::t_entry  i_head,
    output logic              o_pop,
    input  logic [63:0]       i_dest_address,
    input  logic [7:0]        i_frame_id,
    input  logic [7:0]        i_query_frame_id,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_run_end,
    output logic              o_frame_end,
    output logic              o_error
);
    import rafb_pkg::*;

    logic [4:0] r_idx;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_end;
    logic       r_frame_end;
    logic       r_error;

    logic       advance;
    logic       empty;
    logic [8:0] frame_len;
    logic [7:0] check;
    logic [2:0] dest_sel;
    logic [7:0] dest_byte;
    logic [7:0] byte_val;
    logic       summed;
    logic       last;
    logic       fend;
    logic       err;

    assign empty     = (i_head.count == 8'd0);
    assign frame_len = {1'b0, i_head.count}
                     + ((i_head.kind == K_CMD) ? CMD_OVERHEAD : TX_OVERHEAD);
    assign check     = CHECK_BASE - r_sum;
    assign dest_sel  = 3'(5'd12 - r_idx);
    assign dest_byte = 8'(i_dest_address >> {dest_sel, 3'b000});
    assign advance   = i_head_valid && (!r_valid || !i_stall);
    assign o_pop     = advance && last;

    always_comb begin
        byte_val = 8'd0;
        summed   = 1'b0;
        last     = 1'b0;
        fend     = 1'b0;
        err      = 1'b0;
        case (i_head.kind)
            K_CMD, K_TX: begin
                case (r_idx)
                    5'd0: byte_val = START_BYTE;
                    5'd1: byte_val = {7'd0, frame_len[8]};
                    5'd2: byte_val = frame_len[7:0];
                    5'd3: begin
                        byte_val = (i_head.kind == K_CMD) ? TYPE_COMMAND : TYPE_TRANSMIT;
                        summed   = 1'b1;
                    end
                    5'd4: begin
                        byte_val = (i_head.kind == K_CMD && empty) ?
                                   i_query_frame_id : i_frame_id;
                        summed   = 1'b1;
                    end
                    default: begin
                        summed = 1'b1;
                        if (i_head.kind == K_CMD) begin
                            if (r_idx == 5'd5) begin
                                byte_val = i_head.cmd_first;
                            end else if (r_idx == 5'd6) begin
                                byte_val = i_head.cmd_second;
                                last     = !empty;
                            end else begin
                                byte_val = check;
                                summed   = 1'b0;
                                last     = 1'b1;
                                fend     = 1'b1;
                            end
                        end else begin
                            if (r_idx inside {[5:12]}) begin
                                byte_val = dest_byte;
                            end else if (r_idx == 5'd13) begin
                                byte_val = BCAST_HI;
                            end else if (r_idx == 5'd14) begin
                                byte_val = BCAST_LO;
                            end else if (r_idx == 5'd15) begin
                                byte_val = 8'd0;
                            end else if (r_idx == 5'd16) begin
                                byte_val = 8'd0;
                                last     = !empty;
                            end else begin
                                byte_val = check;
                                summed   = 1'b0;
                                last     = 1'b1;
                                fend     = 1'b1;
                            end
                        end
                    end
                endcase
            end
            K_PAY: begin
                byte_val = i_head.data;
                summed   = 1'b1;
                last     = 1'b1;
            end
            K_PAY_LAST: begin
                if (r_idx == 5'd0) begin
                    byte_val = i_head.data;
                    summed   = 1'b1;
                end else begin
                    byte_val = check;
                    last     = 1'b1;
                    fend     = 1'b1;
                end
            end
            K_STRAY: begin
                err  = 1'b1;
                last = 1'b1;
            end
            K_ESC: begin
                byte_val = escape_char(r_idx[2:0]);
                last     = (r_idx == 5'd5);
                fend     = last;
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_sum = r_sum;
        if ((i_head.kind == K_CMD || i_head.kind == K_TX) && r_idx == 5'd0) begin
            n_sum = 8'd0;
        end else if (i_head.kind == K_ESC) begin
            n_sum = 8'd0;
        end else if (summed) begin
            n_sum = r_sum + byte_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_idx   <= last ? 5'd0 : r_idx + 5'd1;
            r_sum   <= n_sum;
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte      <= byte_val;
            r_run_end   <= last;
            r_frame_end <= fend;
            r_error     <= err;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_run_end   = r_run_end;
    assign o_frame_end = r_frame_end;
    assign o_error     = r_error;

endmodule

// ===== tb/tb_radio_api_frame_builder_top.sv =====
// Self-checking testbench for radio_api_frame_builder_top: frame, payload and escape
// requests with random gaps and output stalls, byte stream checked against a predictor.
// Depends on rafb_pkg and radio_api_frame_builder_top.
`timescale 1ns / 1ps

module tb_radio_api_frame_builder_top;
    import rafb_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       run_end;
        logic       frame_end;
        logic       error;
    } t_serial_byte;

    class api_frame_scoreboard;
        localparam int          MAX_PAYLOAD = 255;
        localparam logic [47:0] ESCAPE_SEQ  = "+++AP1";

        logic [63:0]  tx_dest;
        logic [7:0]   tx_frame_id;
        logic [7:0]   query_id;
        logic [7:0]   remaining;
        logic [7:0]   checksum_acc;
        logic         in_frame;
        t_serial_byte pending_bytes[$];
        int           errors;

        function new();
            tx_dest      = 64'h0013_A200_40B6_683D;
            tx_frame_id  = 8'h01;
            query_id     = 8'h52;
            remaining    = '0;
            checksum_acc = '0;
            in_frame     = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                CFG_DEST_ADDRESS:   tx_dest     = data;
                CFG_FRAME_ID:       tx_frame_id = data[7:0];
                CFG_QUERY_FRAME_ID: query_id    = data[7:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic fend, logic err);
            t_serial_byte e;
            e.value     = b;
            e.run_end   = 1'b0;
            e.frame_end = fend;
            e.error     = err;
            pending_bytes.push_back(e);
        endfunction

        function void push_summed(logic [7:0] b);
            checksum_acc = checksum_acc + b;
            push_byte(b, 1'b0, 1'b0);
        endfunction

        function void close_frame();
            in_frame  = 1'b0;
            remaining = '0;
            push_byte(8'hFF - checksum_acc, 1'b1, 1'b0);
        endfunction

        function void take_item(logic [1:0] op, logic [7:0] c1, logic [7:0] c2,
                                logic [7:0] n_in, logic [7:0] db);
            int          cnt;
            logic [15:0] len;
            cnt = n_in;
            if (cnt > MAX_PAYLOAD) cnt = MAX_PAYLOAD;
            case (op)
                OP_CMD_HDR, OP_TX_HDR: begin
                    len = 16'(cnt) + ((op == OP_CMD_HDR) ? 16'(CMD_OVERHEAD)
                                                         : 16'(TX_OVERHEAD));
                    checksum_acc = '0;
                    push_byte(START_BYTE, 1'b0, 1'b0);
                    push_byte(len[15:8], 1'b0, 1'b0);
                    push_byte(len[7:0], 1'b0, 1'b0);
                    if (op == OP_CMD_HDR) begin
                        push_summed(TYPE_COMMAND);
                        push_summed((cnt == 0) ? query_id : tx_frame_id);
                        push_summed(c1);
                        push_summed(c2);
                    end else begin
                        push_summed(TYPE_TRANSMIT);
                        push_summed(tx_frame_id);
                        for (int i = 7; i >= 0; i--) push_summed(tx_dest[i*8 +: 8]);
                        push_summed(BCAST_HI);
                        push_summed(BCAST_LO);
                        push_summed(8'h00);
                        push_summed(8'h00);
                    end
                    if (cnt == 0) begin
                        close_frame();
                    end else begin
                        in_frame  = 1'b1;
                        remaining = 8'(cnt);
                    end
                end
                OP_PAYLOAD: begin
                    if (!in_frame) begin
                        push_byte(8'h00, 1'b0, 1'b1);
                    end else begin
                        push_summed(db);
                        remaining = remaining - 8'd1;
                        if (remaining == 8'd0) close_frame();
                    end
                end
                default: begin
                    in_frame     = 1'b0;
                    remaining    = '0;
                    checksum_acc = '0;
                    for (int i = 0; i < 6; i++)
                        push_byte(ESCAPE_SEQ[47 - 8*i -: 8], i == 5, 1'b0);
                end
            endcase
            pending_bytes[pending_bytes.size() - 1].run_end = 1'b1;
        endfunction

        function void match_byte(logic [7:0] b, logic re, logic fe, logic err);
            t_serial_byte e;
            if (pending_bytes.size() == 0) begin
                $error("unexpected output byte %02h", b);
                errors++;
                return;
            end
            e = pending_bytes.pop_front();
            if (b !== e.value) begin
                $error("out_byte: expected %02h, got %02h", e.value, b);
                errors++;
            end
            if (re !== e.run_end) begin
                $error("run_end: expected %0b, got %0b", e.run_end, re);
                errors++;
            end
            if (fe !== e.frame_end) begin
                $error("frame_end: expected %0b, got %0b", e.frame_end, fe);
                errors++;
            end
            if (err !== e.error) begin
                $error("error: expected %0b, got %0b", e.error, err);
                errors++;
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    localparam int          STALL_LIMIT = 1000;
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [7:0]  i_cmd_first;
    logic [7:0]  i_cmd_second;
    logic [7:0]  i_payload_length;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_run_end;
    logic        o_frame_end;
    logic        o_error;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    api_frame_scoreboard frames;
    int                  tx_gap_max;
    int                  rx_hold_max;
    int                  items_sent;
    int                  idle_cycles;

    radio_api_frame_builder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_cmd_first      (i_cmd_first),
        .i_cmd_second     (i_cmd_second),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_run_end        (o_run_end),
        .o_frame_end      (o_frame_end),
        .o_error          (o_error),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : rx_side
        int hold;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            hold = $urandom_range(0, rx_hold_max);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            frames.match_byte(o_out_byte, o_run_end, o_frame_end, o_error);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] c1, input logic [7:0] c2,
                             input logic [7:0] n, input logic [7:0] db);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_opcode         <= op;
        i_cmd_first      <= c1;
        i_cmd_second     <= c2;
        i_payload_length <= n;
        i_data_byte      <= db;
        do @(posedge i_clk); while (o_stall);
        frames.take_item(op, c1, c2, n, db);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [1:0] op, input int n, input int cut);
        send_item(op, 8'($urandom), 8'($urandom), 8'(n), 8'($urandom));
        repeat (cut) send_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (frames.pending() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        frames.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic set_registers(input logic [63:0] dest, input logic [7:0] fid,
                                 input logic [7:0] qid, input bit with_unused);
        write_reg(CFG_DEST_ADDRESS, dest);
        write_reg(CFG_FRAME_ID, {56'($urandom), fid});
        write_reg(CFG_QUERY_FRAME_ID, {56'($urandom), qid});
        if (with_unused) write_reg(CFG_UNUSED, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int target);
        int   start;
        int   kind;
        int   n;
        logic [1:0] op;
        start = items_sent;
        while (items_sent - start < target) begin
            if ($urandom_range(0, 5) == 0) begin
                tx_gap_max  = $urandom_range(0, 1) * 3;
                rx_hold_max = $urandom_range(0, 1) * 3;
            end
            op   = $urandom_range(0, 1) ? OP_TX_HDR : OP_CMD_HDR;
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                case ($urandom_range(0, 7))
                    0:       n = 0;
                    1:       n = $urandom_range(16, 40);
                    default: n = $urandom_range(1, 8);
                endcase
                send_frame(op, n, n);
            end else if (kind == 8) begin
                n = $urandom_range(1, 255);
                send_frame(op, n, $urandom_range(0, (n > 5) ? 5 : n - 1));
            end else if ($urandom_range(0, 1)) begin
                send_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_item(OP_ESCAPE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        frames           = new();
        tx_gap_max       = 3;
        rx_hold_max      = 3;
        items_sent       = 0;
        idle_cycles      = 0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_opcode         = OP_CMD_HDR;
        i_cmd_first      = '0;
        i_cmd_second     = '0;
        i_payload_length = '0;
        i_data_byte      = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_DEST_ADDRESS;
        i_cfg_data       = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(OP_CMD_HDR, 8'h00, 8'hFF, 8'd0, 8'h00);
        send_item(OP_TX_HDR, 8'hFF, 8'h00, 8'd0, 8'hFF);
        send_item(OP_CMD_HDR, "A", "T", 8'd1, 8'h00);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 8'h5A);
        send_item(OP_TX_HDR, 8'h00, 8'h00, 8'd255, 8'h00);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(OP_CMD_HDR, 8'hFF, 8'h00, 8'd252, 8'h00);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h55);
        send_item(OP_ESCAPE, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hA5);
        send_item(OP_ESCAPE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_TX_HDR, 8'h00, 8'h00, 8'd2, 8'h00);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h80);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h7F);
        send_item(OP_CMD_HDR, "N", "I", 8'd3, 8'h00);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h01);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h02);
        send_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h03);

        for (int p = 1; p <= 5; p++) begin
            drain();
            case (p)
                1:       set_registers('0, 8'h00, 8'h00, 1'b0);
                2:       set_registers('1, 8'hFF, 8'hFF, 1'b1);
                default: set_registers({$urandom, $urandom}, 8'($urandom), 8'($urandom),
                                       p == 4);
            endcase
            run_random(70);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (frames.errors == 0 && frames.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
